// ----- rtl/wnm_pkg.sv -----
package wnm_pkg;

    localparam int PATTERN_MAX  = 32;
    localparam int POS_W        = PATTERN_MAX + 1;
    localparam int LEN_W        = $clog2(POS_W);
    localparam int CHAR_W       = 8;
    localparam int DATA_W       = 64;
    localparam int CHARS_PER_REG = DATA_W / CHAR_W;
    localparam int NUM_PAT_REGS = PATTERN_MAX / CHARS_PER_REG;
    localparam int NUM_REGS     = NUM_PAT_REGS + 1;
    localparam int IDX_W        = $clog2(NUM_REGS);
    localparam int ADDR_W       = IDX_W + 3;
    localparam int CLOSE_STEPS  = $clog2(POS_W);

    localparam logic [IDX_W-1:0] REG_PAT_LOW      = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_PAT_MID_LOW  = IDX_W'(1);
    localparam logic [IDX_W-1:0] REG_PAT_MID_HIGH = IDX_W'(2);
    localparam logic [IDX_W-1:0] REG_PAT_HIGH     = IDX_W'(3);
    localparam logic [IDX_W-1:0] REG_PAT_LENGTH   = IDX_W'(4);

    localparam logic [CHAR_W-1:0] STAR_CHAR = 8'h2A;
    localparam logic [CHAR_W-1:0] ANY_CHAR  = 8'h3F;

    typedef logic [POS_W-1:0] pos_vec_t;

    typedef struct packed {
        logic [PATTERN_MAX-1:0][CHAR_W-1:0] chars;
        logic [LEN_W-1:0]                   len;
        logic                               rewind;
    } wnm_cfg_t;

    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A)
        begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // extend across stars that match nothing: prefix OR gated by star runs
    function automatic pos_vec_t star_closure(
        input pos_vec_t                v,
        input logic [PATTERN_MAX-1:0] star,
        input pos_vec_t                keep
    );
        pos_vec_t g;
        pos_vec_t p;
        g = v;
        p = {star, 1'b0};
        for (int k = 0; k < CLOSE_STEPS; k++)
        begin
            g = g | (p & (g << (1 << k)));
            p = p & (p << (1 << k));
        end
        return g & keep;
    endfunction

endpackage

// ----- rtl/wnm_if.sv -----
interface wnm_in_if;
    logic                  valid;
    logic                  ready;
    logic [7:0]            name_char;
    logic                  no_char;
    logic                  is_last;

    modport source (output valid, output name_char, output no_char, output is_last,
                    input ready);
    modport sink (input valid, input name_char, input no_char, input is_last,
                  output ready);
endinterface

interface wnm_out_if;
    logic valid;
    logic ready;
    logic matched;

    modport source (output valid, output matched, input ready);
    modport sink (input valid, input matched, output ready);
endinterface

// ----- rtl/wnm_cfg.sv -----
module wnm_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wnm_pkg::ADDR_W-1:0]  paddr,
    input  logic [wnm_pkg::DATA_W-1:0]  pwdata,
    output logic [wnm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output wnm_pkg::wnm_cfg_t           cfg
);
    import wnm_pkg::*;

    logic [NUM_PAT_REGS-1:0][DATA_W-1:0] pat_reg;
    logic [LEN_W-1:0]                    len_reg;
    logic [IDX_W-1:0]                    idx;
    logic                                wr_en;

    assign idx    = paddr[ADDR_W-1:3];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_reg <= '0;
            len_reg <= '0;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH:
                begin
                    pat_reg[idx[$clog2(NUM_PAT_REGS)-1:0]] <= pwdata;
                end
                REG_PAT_LENGTH:
                begin
                    len_reg <= pwdata[LEN_W-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH:
            begin
                prdata = pat_reg[idx[$clog2(NUM_PAT_REGS)-1:0]];
            end
            REG_PAT_LENGTH:
            begin
                prdata = DATA_W'(len_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_comb
    begin
        cfg.chars  = pat_reg;
        cfg.len    = (len_reg > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_reg;
        cfg.rewind = wr_en && (idx < IDX_W'(NUM_REGS));
    end

endmodule

// ----- rtl/wildcard_name_matcher.sv -----
// Wildcard name matcher.
// Tests a name, streamed one byte per word on in_ch, against a glob pattern
// held in the APB registers ('*' any run, '?' any byte, letters compared
// without case). Each in_ch word carries name_char, no_char and is_last.
// A word with is_last set closes the name and yields one out_ch word whose
// matched bit tells whether the whole name fits the whole pattern; the block
// then rewinds for the next name. Words without is_last produce nothing.
// Throughput: one name byte per cycle unless a waiting result stalls in_ch;
// the position-vector update is a single registered step. Latency: the
// result is valid the cycle after the closing word is accepted.
// A stalled out_ch holds its word; in_ch stays ready while out_ch is free or
// being drained, and a waiting result stalls in_ch until out_ch takes it.
// Reset clears the pattern to empty and the length to zero. A write to any
// defined register rewinds the match state; write registers only while the block is idle.
module wildcard_name_matcher (
    input  logic                        clk,
    input  logic                        rst_n,
    wnm_in_if.sink                      in_ch,
    wnm_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [wnm_pkg::ADDR_W-1:0]  paddr,
    input  logic [wnm_pkg::DATA_W-1:0]  pwdata,
    output logic [wnm_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import wnm_pkg::*;

    wnm_cfg_t                    cfg;
    logic [PATTERN_MAX-1:0]      star_mask;
    logic [PATTERN_MAX-1:0]      lit_hit;
    logic [PATTERN_MAX-1:0]      in_len;
    pos_vec_t                    keep_mask;
    pos_vec_t                    start_vec;
    pos_vec_t                    cur;
    pos_vec_t                    stepped;
    pos_vec_t                    advanced;
    logic [CHAR_W-1:0]           in_fold;
    logic                        accept;
    logic                        matched_now;

    pos_vec_t                    pos_reg;
    pos_vec_t                    pos_next;
    logic                        restart_reg;
    logic                        restart_next;
    logic                        res_valid_reg;
    logic                        res_valid_next;
    logic                        res_matched_reg;
    logic                        res_matched_next;

    wnm_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign in_fold = fold_char(in_ch.name_char);

    always_comb
    begin
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            in_len[i]    = LEN_W'(i) < cfg.len;
            star_mask[i] = in_len[i] && (cfg.chars[i] == STAR_CHAR);
            lit_hit[i]   = (cfg.chars[i] == ANY_CHAR) || (fold_char(cfg.chars[i]) == in_fold);
        end
        for (int j = 0; j < POS_W; j++)
        begin
            keep_mask[j] = LEN_W'(j) <= cfg.len;
        end
    end

    assign start_vec = star_closure(POS_W'(1), star_mask, keep_mask);
    assign cur       = restart_reg ? start_vec : pos_reg;

    always_comb
    begin
        stepped = '0;
        for (int i = 0; i < PATTERN_MAX; i++)
        begin
            if (cur[i] && in_len[i])
            begin
                if (star_mask[i])
                begin
                    stepped[i] = 1'b1;
                end
                else if (lit_hit[i])
                begin
                    stepped[i+1] = 1'b1;
                end
            end
        end
    end

    assign advanced    = in_ch.no_char ? cur : star_closure(stepped, star_mask, keep_mask);
    assign matched_now = advanced[cfg.len];

    assign in_ch.ready    = !res_valid_reg || out_ch.ready;
    assign accept         = in_ch.valid && in_ch.ready;
    assign out_ch.valid   = res_valid_reg;
    assign out_ch.matched = res_matched_reg;

    always_comb
    begin
        pos_next         = pos_reg;
        restart_next     = restart_reg;
        res_valid_next   = res_valid_reg && !out_ch.ready;
        res_matched_next = res_matched_reg;
        if (cfg.rewind)
        begin
            restart_next = 1'b1;
        end
        else if (accept)
        begin
            if (in_ch.is_last)
            begin
                restart_next     = 1'b1;
                res_valid_next   = 1'b1;
                res_matched_next = matched_now;
            end
            else
            begin
                pos_next     = advanced;
                restart_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restart_reg   <= 1'b1;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            restart_reg   <= restart_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg         <= pos_next;
        res_matched_reg <= res_matched_next;
    end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
    import wnm_pkg::*;

    localparam int unsigned QUIET_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned RANDOM_WORDS = 500;
    localparam int unsigned WORDS_PER_PHASE = 45;
    localparam int unsigned DRAIN_CYCLES = 4;
    localparam logic [IDX_W-1:0] REG_UNUSED = IDX_W'(NUM_REGS);
    localparam logic [IDX_W-1:0] PAT_REGS[NUM_PAT_REGS] =
        '{REG_PAT_LOW, REG_PAT_MID_LOW, REG_PAT_MID_HIGH, REG_PAT_HIGH};

    class name_match_predictor;
        byte unsigned pat[PATTERN_MAX];
        bit [5:0] pat_len;
        pos_vec_t live;
        bit pending_matches[$];
        int unsigned errors;

        function new();
            foreach (pat[i])
            begin
                pat[i] = 8'h00;
            end
            pat_len = '0;
            errors = 0;
            rewind();
        endfunction

        function int unsigned eff_len();
            return (pat_len > PATTERN_MAX) ? PATTERN_MAX : pat_len;
        endfunction

        function byte unsigned lower(byte unsigned c);
            return (c >= 8'h41 && c <= 8'h5A) ? c + 8'h20 : c;
        endfunction

        function pos_vec_t close_stars(pos_vec_t v);
            int unsigned n;
            pos_vec_t keep;
            n = eff_len();
            for (int i = 0; i < n; i++)
            begin
                if (v[i] && pat[i] == STAR_CHAR)
                begin
                    v[i+1] = 1'b1;
                end
            end
            keep = (pos_vec_t'(1) << (n + 1)) - pos_vec_t'(1);
            return v & keep;
        endfunction

        function void rewind();
            live = close_stars(pos_vec_t'(1));
        endfunction

        function void note_write(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
            if (idx < REG_PAT_LENGTH)
            begin
                for (int k = 0; k < CHARS_PER_REG; k++)
                begin
                    pat[idx*CHARS_PER_REG + k] = val[k*CHAR_W +: CHAR_W];
                end
            end
            else if (idx == REG_PAT_LENGTH)
            begin
                pat_len = val[5:0];
            end
            else
            begin
                return;
            end
            rewind();
        endfunction

        function void take_word(byte unsigned c, bit nc, bit last);
            pos_vec_t nxt;
            int unsigned n;
            n = eff_len();
            if (!nc)
            begin
                nxt = '0;
                for (int i = 0; i < n; i++)
                begin
                    if (live[i])
                    begin
                        if (pat[i] == STAR_CHAR)
                        begin
                            nxt[i] = 1'b1;
                        end
                        else if (pat[i] == ANY_CHAR || lower(pat[i]) == lower(c))
                        begin
                            nxt[i+1] = 1'b1;
                        end
                    end
                end
                live = close_stars(nxt);
            end
            if (last)
            begin
                pending_matches.push_back(live[n]);
                rewind();
            end
        endfunction

        function void compare_match(bit got);
            bit want;
            if (pending_matches.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual matched=%0b",
                         $time, got);
                errors++;
            end
            else
            begin
                want = pending_matches.pop_front();
                if (want != got)
                begin
                    $display("%0t: matched mismatch, expected %0b, actual %0b",
                             $time, want, got);
                    errors++;
                end
            end
        endfunction

        function int unsigned waiting();
            return pending_matches.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic pready;

    wnm_in_if in_if();
    wnm_out_if out_if();

    name_match_predictor predict = new();

    bit calm;
    bit hold_request;
    int unsigned words_sent;
    int unsigned quiet_cycles;

    wildcard_name_matcher u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_if),
        .out_ch  (out_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver: random stalls, quiet stretches, one long hold-off on request
    initial
    begin
        int unsigned stall_left;
        int unsigned hold_left;
        int unsigned r;
        stall_left = 0;
        hold_left = 0;
        out_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            r = $urandom_range(0, 99);
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                out_if.ready <= 1'b0;
                hold_left--;
            end
            else if (calm)
            begin
                out_if.ready <= 1'b1;
            end
            else if (stall_left > 0)
            begin
                out_if.ready <= 1'b0;
                stall_left--;
            end
            else if (r < 12)
            begin
                out_if.ready <= 1'b0;
                stall_left = $urandom_range(0, 2);
            end
            else if (r < 14)
            begin
                out_if.ready <= 1'b0;
                stall_left = $urandom_range(10, 40);
            end
            else
            begin
                out_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_if.valid && out_if.ready)
        begin
            predict.compare_match(out_if.matched);
        end
    end

    always @(posedge clk)
    begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || psel)
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic byte unsigned pick_alpha();
        case ($urandom_range(0, 5))
            0: return 8'h61;
            1: return 8'h41;
            2: return 8'h62;
            3: return 8'h42;
            4: return 8'h63;
            default: return 8'h43;
        endcase
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (calm || r < 70)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 30);
    endfunction

    function automatic void make_pattern(output byte unsigned p[PATTERN_MAX],
                                         output bit [5:0] n, input int unsigned phase);
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 99);
        case (phase)
            0: n = 6'd0;
            1: n = 6'd32;
            2: n = 6'($urandom_range(33, 63));
            default:
            begin
                if (r < 8)
                    n = 6'd0;
                else if (r < 16)
                    n = 6'd32;
                else if (r < 22)
                    n = 6'($urandom_range(33, 63));
                else if (r < 28)
                    n = 6'd1;
                else
                    n = 6'($urandom_range(2, 10));
            end
        endcase
        foreach (p[i])
        begin
            k = $urandom_range(0, 99);
            if (k < 22)
                p[i] = STAR_CHAR;
            else if (k < 37)
                p[i] = ANY_CHAR;
            else if (k < 77)
                p[i] = pick_alpha();
            else if (k < 85)
                p[i] = 8'h00;
            else
                p[i] = 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic void make_name(input byte unsigned p[PATTERN_MAX], input bit [5:0] n,
                                      output byte unsigned nm[$]);
        int unsigned used;
        byte unsigned t;
        nm = {};
        used = (n > PATTERN_MAX) ? PATTERN_MAX : n;
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(0, 6))
            begin
                t = $urandom_range(0, 1) ? pick_alpha() : 8'($urandom_range(0, 255));
                nm.push_back(t);
            end
        end
        else
        begin
            for (int i = 0; i < used; i++)
            begin
                t = p[i] | 8'h20;
                if (p[i] == STAR_CHAR)
                begin
                    repeat ($urandom_range(0, 3)) nm.push_back(pick_alpha());
                end
                else if (p[i] == ANY_CHAR)
                begin
                    nm.push_back(8'($urandom_range(0, 255)));
                end
                else if (t >= 8'h61 && t <= 8'h7A && $urandom_range(0, 1))
                begin
                    nm.push_back(p[i] ^ 8'h20);
                end
                else
                begin
                    nm.push_back(p[i]);
                end
            end
            if ($urandom_range(0, 6) == 0 && nm.size() != 0)
            begin
                nm[$urandom_range(0, nm.size() - 1)] = pick_alpha();
            end
        end
    endfunction

    task automatic send_word(byte unsigned c, bit nc, bit last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.name_char <= c;
        in_if.no_char <= nc;
        in_if.is_last <= last;
        do @(posedge clk); while (!in_if.ready);
        predict.take_word(c, nc, last);
        words_sent++;
    endtask

    task automatic send_name(byte unsigned nm[$]);
        bit tail_empty;
        tail_empty = ($urandom_range(0, 9) == 0);
        if (nm.size() == 0)
        begin
            send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        end
        else
        begin
            foreach (nm[i])
            begin
                if ($urandom_range(0, 19) == 0)
                begin
                    send_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
                end
                send_word(nm[i], 1'b0, (i == nm.size() - 1) && !tail_empty);
            end
            if (tail_empty)
            begin
                send_word(8'($urandom_range(0, 255)), 1'b1, 1'b1);
            end
        end
    endtask

    // drop valid and wait out every outstanding result
    task automatic drain();
        in_if.valid <= 1'b0;
        do @(posedge clk); while (predict.waiting() != 0);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        predict.note_write(idx, val);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_pattern(byte unsigned p[PATTERN_MAX], bit [5:0] n);
        logic [DATA_W-1:0] val;
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        for (int r = 0; r < NUM_PAT_REGS; r++)
        begin
            for (int k = 0; k < CHARS_PER_REG; k++)
            begin
                val[k*CHAR_W +: CHAR_W] = p[r*CHARS_PER_REG + k];
            end
            write_reg(PAT_REGS[r], val);
        end
        write_reg(REG_PAT_LENGTH, DATA_W'(n));
    endtask

    initial
    begin
        byte unsigned p[PATTERN_MAX];
        byte unsigned nm[$];
        bit [5:0] n;
        int unsigned target;
        int unsigned phase;
        int unsigned phase_start;
        bit paused;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        in_if.valid = 1'b0;
        in_if.name_char = 8'h00;
        in_if.no_char = 1'b0;
        in_if.is_last = 1'b0;
        calm = 1'b0;
        hold_request = 1'b0;
        words_sent = 0;
        quiet_cycles = 0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty pattern after reset: only the empty name fits
        send_word(8'hFF, 1'b1, 1'b1);
        send_word(8'h41, 1'b0, 1'b1);
        drain();
        repeat (DRAIN_CYCLES) @(posedge clk);
        write_reg(REG_UNUSED, '1);

        // leading star with a repeated prefix byte, case folding, empty words
        foreach (p[i])
        begin
            p[i] = 8'h00;
        end
        p[0] = STAR_CHAR;
        p[1] = 8'h61;
        p[2] = 8'h62;
        load_pattern(p, 6'd3);
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'h62, 1'b0, 1'b1);
        send_word(8'h41, 1'b0, 1'b0);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'h42, 1'b0, 1'b1);
        send_word(8'h62, 1'b0, 1'b1);
        send_word(8'h61, 1'b0, 1'b0);
        send_word(8'h62, 1'b0, 1'b0);
        send_word(8'h63, 1'b0, 1'b1);

        // any byte, zero literal, upper-case literal, trailing star
        p[0] = ANY_CHAR;
        p[1] = 8'h00;
        p[2] = 8'h5A;
        p[3] = STAR_CHAR;
        load_pattern(p, 6'd4);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h7A, 1'b0, 1'b1);
        send_word(8'h71, 1'b0, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h59, 1'b0, 1'b1);

        // all ones in every register, length beyond the maximum
        foreach (p[i])
        begin
            p[i] = 8'hFF;
        end
        load_pattern(p, 6'd63);
        send_word(8'hFF, 1'b1, 1'b1);

        // all stars over the full length
        foreach (p[i])
        begin
            p[i] = STAR_CHAR;
        end
        load_pattern(p, 6'd32);
        send_word(8'h00, 1'b1, 1'b1);
        send_word(8'h7A, 1'b0, 1'b1);

        target = words_sent + RANDOM_WORDS;
        phase = 0;
        while (words_sent < target)
        begin
            make_pattern(p, n, phase);
            load_pattern(p, n);
            calm = (phase % 4 == 2);
            if (phase == 3)
            begin
                hold_request = 1'b1;
            end
            phase_start = words_sent;
            paused = 1'b0;
            while (words_sent - phase_start < WORDS_PER_PHASE && words_sent < target)
            begin
                if (phase == 5 && !paused && words_sent - phase_start >= 20)
                begin
                    drain();
                    paused = 1'b1;
                end
                make_name(p, n, nm);
                send_name(nm);
            end
            phase++;
        end
        calm = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (predict.errors == 0 && predict.waiting() == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- wildcard_name_matcher.f -----
rtl/wnm_pkg.sv
rtl/wnm_if.sv
rtl/wnm_cfg.sv
rtl/wildcard_name_matcher.sv
tb/tb.sv
